/* hdl/track_match_trigger_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the track match trigger RTL.
// ----------------------------------------------------------------------------
`ifndef TRACK_MATCH_TRIGGER_ASSERT_SVH
`define TRACK_MATCH_TRIGGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("track match trigger: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("track match trigger: next-cycle check failed");

`endif

/* hdl/tmt_pkg.sv */
// ----------------------------------------------------------------------------
// tmt_pkg
// Constants, payload types and helpers of the track match trigger.
// ----------------------------------------------------------------------------
package tmt_pkg;

    localparam int NUM_CELLS        = 64;
    localparam int BARREL_TOF_COUNT = 88;
    localparam int ENDCAP_TOF_COUNT = 24;
    localparam int BARREL_EMC_COUNT = 30;
    localparam int ENDCAP_EMC_COUNT = 16;
    localparam int OPPOSITE_WINDOW  = 7;

    localparam int BB_OFFSET = (NUM_CELLS / 2) - (OPPOSITE_WINDOW / 2);
    localparam int TOF_TOTAL = BARREL_TOF_COUNT + 2 * ENDCAP_TOF_COUNT;
    localparam int EMC_TOTAL = BARREL_EMC_COUNT + 2 * ENDCAP_EMC_COUNT;

    localparam int CELL_W    = $clog2(NUM_CELLS);
    localparam int TOF_IDX_W = $clog2(TOF_TOTAL);
    localparam int EMC_IDX_W = $clog2(EMC_TOTAL);

    // Map offsets: barrel first, then east, then west.
    localparam int TOF_BASE_BARREL = 0;
    localparam int TOF_BASE_EAST   = BARREL_TOF_COUNT;
    localparam int TOF_BASE_WEST   = BARREL_TOF_COUNT + ENDCAP_TOF_COUNT;
    localparam int EMC_BASE_BARREL = 0;
    localparam int EMC_BASE_EAST   = BARREL_EMC_COUNT;
    localparam int EMC_BASE_WEST   = BARREL_EMC_COUNT + ENDCAP_EMC_COUNT;

    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_LONG  = 3'd1;
    localparam logic [2:0] REQ_SHORT = 3'd2;
    localparam logic [2:0] REQ_TOF   = 3'd3;
    localparam logic [2:0] REQ_EMC   = 3'd4;
    localparam logic [2:0] REQ_EVAL  = 3'd5;

    localparam logic [1:0] REGION_EAST   = 2'd0;
    localparam logic [1:0] REGION_BARREL = 2'd1;
    localparam logic [1:0] REGION_WEST   = 2'd2;

    localparam int         CFG_ADDR_W         = 3;
    localparam logic [2:0] CFG_ENDCAP_MODE    = 3'd0;

    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] region;
        logic [5:0] cell_req;
        logic [6:0] hit_id;
        logic [6:0] tof_low;
        logic [6:0] tof_high;
        logic [4:0] emc_low;
        logic [4:0] emc_high;
    } tmt_in_t;

    typedef struct packed {
        logic a_at_least_one;
        logic a_at_least_two;
        logic a_back_to_back;
        logic b_at_least_one;
        logic b_at_least_two;
        logic b_back_to_back;
        logic c_at_least_one;
        logic c_at_least_two;
        logic c_back_to_back;
    } tmt_out_t;

    typedef struct packed {
        logic [4:0] emc_high;
        logic [4:0] emc_low;
        logic [6:0] tof_high;
        logic [6:0] tof_low;
    } tmt_row_t;

    // One memory word holds the rows of all three regions for one cell.
    typedef tmt_row_t [2:0] tmt_row_set_t;

    typedef struct packed {
        logic              wr_en;
        logic [1:0]        wr_region;
        logic [CELL_W-1:0] wr_cell;
        tmt_row_t          wr_row;
        logic              rd_en;
        logic [CELL_W-1:0] rd_cell;
    } tmt_ram_req_t;

    typedef struct packed {
        logic w_emc;
        logic w_tof;
        logic e_emc;
        logic e_tof;
        logic b_emc;
        logic b_tof;
    } tmt_match_t;

    // Inclusive range test; a low bound above the high bound wraps around.
    function automatic logic in_range(logic [6:0] id, logic [6:0] lo, logic [6:0] hi);
        logic res;
        if (lo <= hi)
            res = (id >= lo) && (id <= hi);
        else
            res = (id >= lo) || (id <= hi);
        return res;
    endfunction

endpackage

/* hdl/tmt_table_ram.sv */
// ----------------------------------------------------------------------------
// tmt_table_ram
// Match table memory, one word per cell holding the three region rows.
// ----------------------------------------------------------------------------
module tmt_table_ram (
    input  logic                  clk,
    input  tmt_pkg::tmt_ram_req_t req,
    output tmt_pkg::tmt_row_set_t rd_data
);

    tmt_pkg::tmt_row_set_t mem [tmt_pkg::NUM_CELLS];
    tmt_pkg::tmt_row_set_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            case (req.wr_region)
                tmt_pkg::REGION_EAST:   mem[req.wr_cell][0] <= req.wr_row;
                tmt_pkg::REGION_BARREL: mem[req.wr_cell][1] <= req.wr_row;
                tmt_pkg::REGION_WEST:   mem[req.wr_cell][2] <= req.wr_row;
                default:                ;
            endcase
        end
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_cell];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/tmt_cell_match.sv */
// ----------------------------------------------------------------------------
// tmt_cell_match
// Matches one cell's three table rows against the TOF and EMC hit maps.
// ----------------------------------------------------------------------------
module tmt_cell_match (
    input  tmt_pkg::tmt_row_set_t            rows,
    input  logic [tmt_pkg::TOF_TOTAL-1:0]    tof_map,
    input  logic [tmt_pkg::EMC_TOTAL-1:0]    emc_map,
    output tmt_pkg::tmt_match_t              match
);

    always_comb
    begin
        match = '0;
        for (int id = 0; id < tmt_pkg::BARREL_TOF_COUNT; id++)
        begin
            if (tof_map[tmt_pkg::TOF_BASE_BARREL + id] &&
                tmt_pkg::in_range(7'(id), rows[1].tof_low, rows[1].tof_high))
                match.b_tof = 1'b1;
        end
        for (int id = 0; id < tmt_pkg::ENDCAP_TOF_COUNT; id++)
        begin
            if (tof_map[tmt_pkg::TOF_BASE_EAST + id] &&
                tmt_pkg::in_range(7'(id), rows[0].tof_low, rows[0].tof_high))
                match.e_tof = 1'b1;
            if (tof_map[tmt_pkg::TOF_BASE_WEST + id] &&
                tmt_pkg::in_range(7'(id), rows[2].tof_low, rows[2].tof_high))
                match.w_tof = 1'b1;
        end
        for (int id = 0; id < tmt_pkg::BARREL_EMC_COUNT; id++)
        begin
            if (emc_map[tmt_pkg::EMC_BASE_BARREL + id] &&
                tmt_pkg::in_range(7'(id), {2'b00, rows[1].emc_low},
                                  {2'b00, rows[1].emc_high}))
                match.b_emc = 1'b1;
        end
        for (int id = 0; id < tmt_pkg::ENDCAP_EMC_COUNT; id++)
        begin
            if (emc_map[tmt_pkg::EMC_BASE_EAST + id] &&
                tmt_pkg::in_range(7'(id), {2'b00, rows[0].emc_low},
                                  {2'b00, rows[0].emc_high}))
                match.e_emc = 1'b1;
            if (emc_map[tmt_pkg::EMC_BASE_WEST + id] &&
                tmt_pkg::in_range(7'(id), {2'b00, rows[2].emc_low},
                                  {2'b00, rows[2].emc_high}))
                match.w_emc = 1'b1;
        end
    end

endmodule

/* hdl/track_match_trigger.sv */
// ----------------------------------------------------------------------------
// track_match_trigger
// Loads the match table, marks tracks and hits of one event and, on evaluate,
// counts matched cells per class, looks for opposite pairs and reports nine trigger flags.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    in_data  (tmt_in_t)
//  out       output     out_valid/out_ready  out_data (tmt_out_t)
//  cfg       input      APB write/read       endcap_mode at address 0
//
// Load, track and hit items are taken while the block is idle.
// Evaluate reads the table memory once per cell, then takes one rotation
// step per cell for the opposite-pair search.
// The result sits in an output register; a new item is taken while it waits,
// unless a second evaluate finishes first, which then holds until it drains.
// Reset clears the hit maps, track masks and endcap_mode; the table is not.
// ----------------------------------------------------------------------------
`include "track_match_trigger_assert.svh"

module track_match_trigger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tmt_pkg::tmt_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tmt_pkg::tmt_out_t                   out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_FLUSH, ST_PAIR, ST_DONE} state_t;

    localparam int N = tmt_pkg::NUM_CELLS;

    state_t                              state_reg;
    logic [tmt_pkg::CELL_W-1:0]          cnt_reg;
    logic                                rd_vld_reg;
    logic [tmt_pkg::CELL_W-1:0]          rd_idx_reg;
    logic [tmt_pkg::TOF_TOTAL-1:0]       tof_map_reg;
    logic [tmt_pkg::EMC_TOTAL-1:0]       emc_map_reg;
    logic [N-1:0]                        long_reg;
    logic [N-1:0]                        short_reg;
    logic [N-1:0]                        a_vec_reg;
    logic [N-1:0]                        b_vec_reg;
    logic [N-1:0]                        c_vec_reg;
    logic [1:0]                          a_cnt_reg;
    logic [1:0]                          b_cnt_reg;
    logic [1:0]                          c_cnt_reg;
    logic                                a_bb_reg;
    logic                                b_bb_reg;
    logic                                c_bb_reg;
    logic                                endcap_mode_reg;
    logic                                out_valid_reg;
    tmt_pkg::tmt_out_t                   out_data_reg;

    tmt_pkg::tmt_ram_req_t               ram_req;
    tmt_pkg::tmt_row_set_t               ram_rows;
    tmt_pkg::tmt_match_t                 match;

    logic                                accept;
    logic                                out_free;
    logic                                cfg_wr;
    logic                                cell_long;
    logic                                cell_short;
    logic                                f_a;
    logic                                f_b;
    logic                                e_ok;
    logic                                w_ok;
    logic [1:0]                          c_inc;
    logic [2:0]                          c_sum;
    logic [tmt_pkg::CELL_W-1:0]          trk_cell;
    logic                                trk_ok;
    logic                                tof_ok;
    logic [tmt_pkg::TOF_IDX_W-1:0]       tof_idx;
    logic [6:0]                          emc_id;
    logic                                emc_ok;
    logic [tmt_pkg::EMC_IDX_W-1:0]       emc_idx;

    tmt_table_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rows)
    );

    tmt_cell_match u_match (
        .rows    (ram_rows),
        .tof_map (tof_map_reg),
        .emc_map (emc_map_reg),
        .match   (match)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = (paddr == tmt_pkg::CFG_ENDCAP_MODE) ? {31'd0, endcap_mode_reg} : 32'd0;

    // Item decode.
    always_comb
    begin
        trk_cell = in_data.hit_id[tmt_pkg::CELL_W:1];
        trk_ok   = {1'b0, in_data.hit_id[6:1]} < 7'(N);
        tof_ok   = 1'b0;
        tof_idx  = '0;
        emc_id   = {1'b0, in_data.hit_id[6:1]};
        emc_ok   = 1'b0;
        emc_idx  = '0;
        case (in_data.region)
            tmt_pkg::REGION_EAST:
            begin
                tof_ok  = in_data.hit_id < 7'(tmt_pkg::ENDCAP_TOF_COUNT);
                tof_idx = tmt_pkg::TOF_IDX_W'(tmt_pkg::TOF_BASE_EAST)
                        + tmt_pkg::TOF_IDX_W'(in_data.hit_id);
                emc_ok  = emc_id < 7'(tmt_pkg::ENDCAP_EMC_COUNT);
                emc_idx = tmt_pkg::EMC_IDX_W'(tmt_pkg::EMC_BASE_EAST)
                        + tmt_pkg::EMC_IDX_W'(emc_id);
            end
            tmt_pkg::REGION_BARREL:
            begin
                tof_ok  = in_data.hit_id < 7'(tmt_pkg::BARREL_TOF_COUNT);
                tof_idx = tmt_pkg::TOF_IDX_W'(in_data.hit_id);
                emc_id  = in_data.hit_id;
                emc_ok  = in_data.hit_id < 7'(tmt_pkg::BARREL_EMC_COUNT);
                emc_idx = tmt_pkg::EMC_IDX_W'(in_data.hit_id);
            end
            tmt_pkg::REGION_WEST:
            begin
                tof_ok  = in_data.hit_id < 7'(tmt_pkg::ENDCAP_TOF_COUNT);
                tof_idx = tmt_pkg::TOF_IDX_W'(tmt_pkg::TOF_BASE_WEST)
                        + tmt_pkg::TOF_IDX_W'(in_data.hit_id);
                emc_ok  = emc_id < 7'(tmt_pkg::ENDCAP_EMC_COUNT);
                emc_idx = tmt_pkg::EMC_IDX_W'(tmt_pkg::EMC_BASE_WEST)
                        + tmt_pkg::EMC_IDX_W'(emc_id);
            end
            default: ;
        endcase
    end

    // Table memory access: loads while idle, one read per cell during the walk.
    always_comb
    begin
        ram_req.wr_en     = accept && (in_data.req_type == tmt_pkg::REQ_LOAD)
                          && ({1'b0, in_data.cell_req} < 7'(N));
        ram_req.wr_region = in_data.region;
        ram_req.wr_cell   = in_data.cell_req[tmt_pkg::CELL_W-1:0];
        ram_req.wr_row    = '{emc_high: in_data.emc_high, emc_low: in_data.emc_low,
                              tof_high: in_data.tof_high, tof_low: in_data.tof_low};
        ram_req.rd_en     = (state_reg == ST_WALK);
        ram_req.rd_cell   = cnt_reg;
    end

    // Per-cell classification of the row that came back from memory.
    always_comb
    begin
        cell_long  = long_reg[rd_idx_reg];
        cell_short = short_reg[rd_idx_reg];
        f_a = cell_long && match.b_tof;
        f_b = f_a && match.b_emc;
        if (endcap_mode_reg)
        begin
            e_ok = cell_short && match.e_tof && match.e_emc;
            w_ok = cell_short && match.w_tof && match.w_emc;
        end
        else
        begin
            e_ok = cell_short && match.e_tof;
            w_ok = cell_short && match.w_tof;
        end
        c_inc = {1'b0, e_ok} + {1'b0, w_ok};
        c_sum = {1'b0, c_cnt_reg} + {1'b0, c_inc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            tof_map_reg     <= '0;
            emc_map_reg     <= '0;
            long_reg        <= '0;
            short_reg       <= '0;
            a_vec_reg       <= '0;
            b_vec_reg       <= '0;
            c_vec_reg       <= '0;
            a_cnt_reg       <= '0;
            b_cnt_reg       <= '0;
            c_cnt_reg       <= '0;
            a_bb_reg        <= 1'b0;
            b_bb_reg        <= 1'b0;
            c_bb_reg        <= 1'b0;
            endcap_mode_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (cfg_wr && (paddr == tmt_pkg::CFG_ENDCAP_MODE))
                endcap_mode_reg <= pwdata[0];

            // In the done state the result register is handled below.
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            rd_vld_reg <= (state_reg == ST_WALK);
            rd_idx_reg <= cnt_reg;

            if (rd_vld_reg)
            begin
                a_vec_reg[rd_idx_reg] <= f_a;
                b_vec_reg[rd_idx_reg] <= f_b;
                c_vec_reg[rd_idx_reg] <= e_ok || w_ok;
                if (f_a && (a_cnt_reg != 2'd2))
                    a_cnt_reg <= a_cnt_reg + 2'd1;
                if (f_b && (b_cnt_reg != 2'd2))
                    b_cnt_reg <= b_cnt_reg + 2'd1;
                c_cnt_reg <= (c_sum > 3'd2) ? 2'd2 : c_sum[1:0];
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.req_type)
                            tmt_pkg::REQ_LONG:
                                if (trk_ok)
                                    long_reg[trk_cell] <= 1'b1;
                            tmt_pkg::REQ_SHORT:
                                if (trk_ok)
                                    short_reg[trk_cell] <= 1'b1;
                            tmt_pkg::REQ_TOF:
                                if (tof_ok)
                                    tof_map_reg[tof_idx] <= 1'b1;
                            tmt_pkg::REQ_EMC:
                                if (emc_ok)
                                    emc_map_reg[emc_idx] <= 1'b1;
                            tmt_pkg::REQ_EVAL:
                            begin
                                state_reg <= ST_WALK;
                                cnt_reg   <= '0;
                                a_cnt_reg <= '0;
                                b_cnt_reg <= '0;
                                c_cnt_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == tmt_pkg::CELL_W'(N - 1))
                        state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_PAIR;
                    cnt_reg   <= '0;
                    a_bb_reg  <= 1'b0;
                    b_bb_reg  <= 1'b0;
                    c_bb_reg  <= 1'b0;
                end
                ST_PAIR:
                begin
                    // Bit 0 is the current cell; the window sits a fixed
                    // distance ahead of it in the rotated vector.
                    if (a_vec_reg[0] && (|a_vec_reg[tmt_pkg::BB_OFFSET +: tmt_pkg::OPPOSITE_WINDOW]))
                        a_bb_reg <= 1'b1;
                    if (b_vec_reg[0] && (|b_vec_reg[tmt_pkg::BB_OFFSET +: tmt_pkg::OPPOSITE_WINDOW]))
                        b_bb_reg <= 1'b1;
                    if (c_vec_reg[0] && (|c_vec_reg[tmt_pkg::BB_OFFSET +: tmt_pkg::OPPOSITE_WINDOW]))
                        c_bb_reg <= 1'b1;
                    a_vec_reg <= {a_vec_reg[0], a_vec_reg[N-1:1]};
                    b_vec_reg <= {b_vec_reg[0], b_vec_reg[N-1:1]};
                    c_vec_reg <= {c_vec_reg[0], c_vec_reg[N-1:1]};
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == tmt_pkg::CELL_W'(N - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= '{a_at_least_one: (a_cnt_reg != 2'd0),
                                           a_at_least_two: (a_cnt_reg == 2'd2),
                                           a_back_to_back: a_bb_reg,
                                           b_at_least_one: (b_cnt_reg != 2'd0),
                                           b_at_least_two: (b_cnt_reg == 2'd2),
                                           b_back_to_back: b_bb_reg,
                                           c_at_least_one: (c_cnt_reg != 2'd0),
                                           c_at_least_two: (c_cnt_reg == 2'd2),
                                           c_back_to_back: c_bb_reg};
                        tof_map_reg   <= '0;
                        emc_map_reg   <= '0;
                        long_reg      <= '0;
                        short_reg     <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    `TMT_ASSERT_NOW(a_rd_in_walk, rd_vld_reg, (state_reg == ST_WALK) || (state_reg == ST_FLUSH))
    `TMT_ASSERT_NEXT(a_eval_starts, accept && (in_data.req_type == tmt_pkg::REQ_EVAL), (state_reg == ST_WALK) && (cnt_reg == '0))
    `TMT_ASSERT_NOW(a_event_cleared, $rose(out_valid_reg), (tof_map_reg == '0) && (long_reg == '0) && (short_reg == '0))

endmodule

/* tb/tb_track_match_trigger.sv */
// ----------------------------------------------------------------------------
// Track match trigger testbench
// Loads the whole match table, then sends short events of tracks and hits,
// each closed by an evaluate item. A scoreboard predicts the nine trigger
// flags of every evaluate and checks them against the output in order.
// The endcap mode register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_track_match_trigger;
    timeunit 1ns;
    timeprecision 1ps;

    class trigger_scoreboard;
        tmt_pkg::tmt_row_t table_rows[3][tmt_pkg::NUM_CELLS];
        bit                tof_map[tmt_pkg::TOF_TOTAL];
        bit                emc_map[tmt_pkg::EMC_TOTAL];
        bit [63:0]         long_cells;
        bit [63:0]         short_cells;
        bit                endcap_mode;
        tmt_pkg::tmt_out_t flags_due[$];
        int                errors;
        int                evals_seen;

        function void clear_event();
            foreach (tof_map[k]) tof_map[k] = 0;
            foreach (emc_map[k]) emc_map[k] = 0;
            long_cells = '0;
            short_cells = '0;
        endfunction

        function bit id_in_range(int id, int lo, int hi);
            if (lo <= hi)
                return id >= lo && id <= hi;
            return id >= lo || id <= hi;
        endfunction

        function int tof_first(int r);
            return r == 1 ? tmt_pkg::TOF_BASE_BARREL
                          : (r == 0 ? tmt_pkg::TOF_BASE_EAST : tmt_pkg::TOF_BASE_WEST);
        endfunction

        function int emc_first(int r);
            return r == 1 ? tmt_pkg::EMC_BASE_BARREL
                          : (r == 0 ? tmt_pkg::EMC_BASE_EAST : tmt_pkg::EMC_BASE_WEST);
        endfunction

        // Bit 0: some TOF hit lies in the cell's range; bit 1: some EMC hit does.
        function bit [1:0] cell_hits(int r, int c);
            tmt_pkg::tmt_row_t row;
            bit [1:0]          m;
            int                nt;
            int                ne;
            row = table_rows[r][c];
            m = 0;
            nt = (r == 1) ? tmt_pkg::BARREL_TOF_COUNT : tmt_pkg::ENDCAP_TOF_COUNT;
            ne = (r == 1) ? tmt_pkg::BARREL_EMC_COUNT : tmt_pkg::ENDCAP_EMC_COUNT;
            for (int id = 0; id < nt; id++)
                if (tof_map[tof_first(r) + id] && id_in_range(id, row.tof_low, row.tof_high))
                    m[0] = 1;
            for (int id = 0; id < ne; id++)
                if (emc_map[emc_first(r) + id] && id_in_range(id, row.emc_low, row.emc_high))
                    m[1] = 1;
            return m;
        endfunction

        function bit opposite_pair(bit [63:0] s);
            for (int i = 0; i < tmt_pkg::NUM_CELLS; i++)
                for (int j = 0; j < tmt_pkg::OPPOSITE_WINDOW; j++)
                    if (s[i] && s[(i + tmt_pkg::BB_OFFSET + j) % tmt_pkg::NUM_CELLS])
                        return 1;
            return 0;
        endfunction

        function void note_item(tmt_pkg::tmt_in_t it);
            int                r;
            int                e;
            int                na;
            int                nb;
            int                nc;
            bit [1:0]          mb;
            bit [1:0]          me;
            bit [1:0]          mw;
            bit                e_ok;
            bit                w_ok;
            bit [63:0]         a_set;
            bit [63:0]         b_set;
            bit [63:0]         c_set;
            tmt_pkg::tmt_out_t f;
            r = it.region;
            case (it.req_type)
                tmt_pkg::REQ_LOAD:
                    if (r < 3)
                        table_rows[r][it.cell_req] = {it.emc_high, it.emc_low,
                                                      it.tof_high, it.tof_low};
                tmt_pkg::REQ_LONG:  long_cells[it.hit_id >> 1] = 1;
                tmt_pkg::REQ_SHORT: short_cells[it.hit_id >> 1] = 1;
                tmt_pkg::REQ_TOF:
                    if (r < 3 && it.hit_id < ((r == 1) ? tmt_pkg::BARREL_TOF_COUNT
                                                       : tmt_pkg::ENDCAP_TOF_COUNT))
                        tof_map[tof_first(r) + it.hit_id] = 1;
                tmt_pkg::REQ_EMC:
                    if (r < 3)
                    begin
                        e = (r == 1) ? it.hit_id : (it.hit_id >> 1);
                        if (e < ((r == 1) ? tmt_pkg::BARREL_EMC_COUNT
                                          : tmt_pkg::ENDCAP_EMC_COUNT))
                            emc_map[emc_first(r) + e] = 1;
                    end
                tmt_pkg::REQ_EVAL:
                begin
                    na = 0;
                    nb = 0;
                    nc = 0;
                    a_set = '0;
                    b_set = '0;
                    c_set = '0;
                    for (int i = 0; i < tmt_pkg::NUM_CELLS; i++)
                    begin
                        mb = long_cells[i] ? cell_hits(1, i) : 2'b00;
                        me = short_cells[i] ? cell_hits(0, i) : 2'b00;
                        mw = short_cells[i] ? cell_hits(2, i) : 2'b00;
                        e_ok = endcap_mode ? (me == 2'b11) : me[0];
                        w_ok = endcap_mode ? (mw == 2'b11) : mw[0];
                        a_set[i] = mb[0];
                        b_set[i] = (mb == 2'b11);
                        c_set[i] = e_ok || w_ok;
                        na += mb[0];
                        nb += (mb == 2'b11);
                        nc += e_ok + w_ok;
                    end
                    f.a_at_least_one = na >= 1;
                    f.a_at_least_two = na >= 2;
                    f.a_back_to_back = opposite_pair(a_set);
                    f.b_at_least_one = nb >= 1;
                    f.b_at_least_two = nb >= 2;
                    f.b_back_to_back = opposite_pair(b_set);
                    f.c_at_least_one = nc >= 1;
                    f.c_at_least_two = nc >= 2;
                    f.c_back_to_back = opposite_pair(c_set);
                    flags_due = {flags_due, f};
                    clear_event();
                end
                default: ;
            endcase
        endfunction

        function void compare_flag(string name, bit want, bit got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
            end
        endfunction

        function void check_flags(tmt_pkg::tmt_out_t got);
            tmt_pkg::tmt_out_t want;
            if (flags_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %b", $time, got);
                return;
            end
            want = flags_due.pop_front();
            evals_seen++;
            compare_flag("a_at_least_one", want.a_at_least_one, got.a_at_least_one);
            compare_flag("a_at_least_two", want.a_at_least_two, got.a_at_least_two);
            compare_flag("a_back_to_back", want.a_back_to_back, got.a_back_to_back);
            compare_flag("b_at_least_one", want.b_at_least_one, got.b_at_least_one);
            compare_flag("b_at_least_two", want.b_at_least_two, got.b_at_least_two);
            compare_flag("b_back_to_back", want.b_back_to_back, got.b_back_to_back);
            compare_flag("c_at_least_one", want.c_at_least_one, got.c_at_least_one);
            compare_flag("c_at_least_two", want.c_at_least_two, got.c_at_least_two);
            compare_flag("c_back_to_back", want.c_back_to_back, got.c_back_to_back);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;

    // Request codes and a region outside the decoded set.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam logic [1:0] REGION_NONE  = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    tmt_pkg::tmt_in_t               in_data;
    logic                           out_valid;
    logic                           out_ready;
    tmt_pkg::tmt_out_t              out_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tmt_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    trigger_scoreboard sb;
    int                cycles;
    int                items_sent;
    int                burst_left;
    int                ready_pct;

    track_match_trigger u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: checks each accepted result and stalls on a drifting duty cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_flags(out_data);
        if (cycles % 300 == 0)
            ready_pct <= ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(15, 90);
        out_ready <= rst_n && ($urandom_range(1, 100) <= ready_pct);
    end

    function automatic tmt_pkg::tmt_in_t make_item(logic [2:0] kind, logic [1:0] r,
                                                   logic [6:0] id);
        tmt_pkg::tmt_in_t it;
        logic [63:0]      raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(tmt_pkg::tmt_in_t)-1:0];
        it.req_type = kind;
        it.region = r;
        it.hit_id = id;
        return it;
    endfunction

    function automatic tmt_pkg::tmt_in_t make_row(logic [1:0] r, int c, int tl, int th,
                                                  int el, int eh);
        tmt_pkg::tmt_in_t it;
        it = make_item(tmt_pkg::REQ_LOAD, r, 7'($urandom));
        it.cell_req = 6'(c);
        it.tof_low = 7'(tl);
        it.tof_high = 7'(th);
        it.emc_low = 5'(el);
        it.emc_high = 5'(eh);
        return it;
    endfunction

    // Sender: keeps valid high through a burst and drops it only for a gap.
    task automatic send_item(tmt_pkg::tmt_in_t it);
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    endtask

    task automatic cfg_write(bit mode);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tmt_pkg::CFG_ENDCAP_MODE;
        pwdata <= {31'($urandom), mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.endcap_mode = mode;
    endtask

    // Every evaluate has finished once its result appears, so the block is idle
    // when all predicted results are checked; a short pause follows.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.flags_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [6:0] hit_for(logic [2:0] kind, logic [1:0] r);
        if ($urandom_range(0, 19) == 0)
            return 7'($urandom);
        case (kind)
            tmt_pkg::REQ_TOF:
                return 7'($urandom_range(0, (r == tmt_pkg::REGION_BARREL) ? 87 : 23));
            tmt_pkg::REQ_EMC:
                return 7'($urandom_range(0, (r == tmt_pkg::REGION_BARREL) ? 29 : 31));
            default:
                return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic random_event();
        int         n;
        logic [2:0] kind;
        logic [1:0] r;
        n = $urandom_range(1, 14);
        for (int k = 0; k < n; k++)
        begin
            kind = 3'($urandom_range(tmt_pkg::REQ_LONG, tmt_pkg::REQ_EMC));
            r = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 24) == 0)
                send_item(make_row(r, $urandom_range(0, 63), $urandom_range(0, 87),
                                   $urandom_range(0, 87), $urandom_range(0, 29),
                                   $urandom_range(0, 29)));
            else
                send_item(make_item(kind, r, hit_for(kind, r)));
        end
        send_item(make_item(tmt_pkg::REQ_EVAL, 2'($urandom), 7'($urandom)));
    endtask

    task automatic noise_burst();
        tmt_pkg::tmt_in_t it;
        logic [63:0]      raw;
        repeat ($urandom_range(1, 5))
        begin
            raw = {$urandom, $urandom};
            it = raw[$bits(tmt_pkg::tmt_in_t)-1:0];
            if (it.req_type == tmt_pkg::REQ_LOAD && it.region != REGION_NONE)
            begin
                it.tof_low = 7'($urandom_range(0, 87));
                it.tof_high = 7'($urandom_range(0, 87));
                it.emc_low = 5'($urandom_range(0, 29));
                it.emc_high = 5'($urandom_range(0, 29));
            end
            send_item(it);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_event();
        sb.endcap_mode = 0;
        sb.errors = 0;
        sb.evals_seen = 0;
        cycles = 0;
        items_sent = 0;
        burst_left = 0;
        ready_pct = 100;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_write(1'b0);

        // Every row is loaded before any evaluate can read it.
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < tmt_pkg::NUM_CELLS; c++)
                send_item(make_row(2'(r), c, $urandom_range(0, 87), $urandom_range(0, 87),
                                   $urandom_range(0, 29), $urandom_range(0, 29)));

        // Directed: wrapped and single-id ranges, id limits, bad region,
        // unknown requests, duplicates, opposite cells and an empty event.
        send_item(make_row(tmt_pkg::REGION_BARREL, 63, 80, 5, 28, 1));
        send_item(make_row(tmt_pkg::REGION_BARREL, 0, 0, 0, 0, 0));
        send_item(make_row(tmt_pkg::REGION_BARREL, 35, 0, 87, 0, 29));
        send_item(make_row(tmt_pkg::REGION_EAST, 63, 23, 0, 15, 0));
        send_item(make_row(REGION_NONE, 1, 87, 87, 29, 29));
        send_item(make_item(tmt_pkg::REQ_LONG, tmt_pkg::REGION_EAST, 7'd127));
        send_item(make_item(tmt_pkg::REQ_LONG, REGION_NONE, 7'd0));
        send_item(make_item(tmt_pkg::REQ_LONG, tmt_pkg::REGION_BARREL, 7'd70));
        send_item(make_item(tmt_pkg::REQ_SHORT, tmt_pkg::REGION_BARREL, 7'd126));
        send_item(make_item(tmt_pkg::REQ_TOF, tmt_pkg::REGION_BARREL, 7'd0));
        send_item(make_item(tmt_pkg::REQ_TOF, tmt_pkg::REGION_BARREL, 7'd0));
        send_item(make_item(tmt_pkg::REQ_TOF, tmt_pkg::REGION_BARREL, 7'd87));
        send_item(make_item(tmt_pkg::REQ_TOF, tmt_pkg::REGION_BARREL, 7'd88));
        send_item(make_item(tmt_pkg::REQ_TOF, tmt_pkg::REGION_EAST, 7'd23));
        send_item(make_item(tmt_pkg::REQ_TOF, tmt_pkg::REGION_WEST, 7'd24));
        send_item(make_item(tmt_pkg::REQ_TOF, REGION_NONE, 7'd5));
        send_item(make_item(tmt_pkg::REQ_EMC, tmt_pkg::REGION_BARREL, 7'd29));
        send_item(make_item(tmt_pkg::REQ_EMC, tmt_pkg::REGION_BARREL, 7'd30));
        send_item(make_item(tmt_pkg::REQ_EMC, tmt_pkg::REGION_EAST, 7'd31));
        send_item(make_item(tmt_pkg::REQ_EMC, tmt_pkg::REGION_WEST, 7'd32));
        send_item(make_item(tmt_pkg::REQ_EMC, REGION_NONE, 7'd1));
        send_item(make_item(REQ_SPARE_LO, tmt_pkg::REGION_BARREL, 7'd3));
        send_item(make_item(REQ_SPARE_HI, tmt_pkg::REGION_EAST, 7'd3));
        send_item(make_item(tmt_pkg::REQ_EVAL, tmt_pkg::REGION_BARREL, 7'd0));
        send_item(make_item(tmt_pkg::REQ_EVAL, tmt_pkg::REGION_BARREL, 7'd0));

        // Random phases with the endcap mode toggled between them.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            cfg_write(ph % 2 == 0);
            while (items_sent < 192 + 25 + (ph + 1) * 170)
            begin
                if ($urandom_range(0, 6) == 0)
                    noise_burst();
                else
                    random_event();
            end
        end

        wait_idle();
        $display("Sent %0d items and checked %0d evaluate results", items_sent, sb.evals_seen);
        $display("over four endcap mode phases with random input gaps and output stalls.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
